// ----- src/tlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light controller package
// Shared sizes, codes, configuration and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package tlc_pkg;

  // Brake window FIFO
  localparam int WIN_DEPTH = 64;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int WIN_CW    = $clog2(WIN_DEPTH + 1);

  // Field widths
  localparam int STAMP_W = 32;
  localparam int YAW_W   = 32;
  localparam int ACCEL_W = 16;

  // Running sum of the window and the brake limit product
  localparam int SUM_W  = ACCEL_W + WIN_AW;
  localparam int BTHR_W = 15;
  localparam int PROD_W = BTHR_W + WIN_CW;
  localparam int CMP_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;

  // Turn test widths: yaw change times 1024 against threshold times elapsed us
  localparam int TTHR_W   = 16;
  localparam int CHANGE_W = YAW_W + 1 + 10;
  localparam int LIMIT_W  = TTHR_W + STAMP_W;
  localparam int TCMP_W   = LIMIT_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLINK_PERIOD = 3'd0,
    REG_TURN_INTERVAL = 3'd1,
    REG_TURN_THR = 3'd2,
    REG_BRAKE_WINDOW = 3'd3,
    REG_BRAKE_THR = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0]       blink_period;
    logic [7:0]        turn_interval;
    logic [TTHR_W-1:0] turn_thr;
    logic [23:0]       brake_window;
    logic [BTHR_W-1:0] brake_thr;
  } cfg_t;

  localparam logic [23:0]       RST_BLINK_PERIOD  = 24'd500000;
  localparam logic [7:0]        RST_TURN_INTERVAL = 8'd50;
  localparam logic [TTHR_W-1:0] RST_TURN_THR      = 16'd100;
  localparam logic [23:0]       RST_BRAKE_WINDOW  = 24'd1000000;
  localparam logic [BTHR_W-1:0] RST_BRAKE_THR     = 15'd1229;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_BLANK = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_TURN,
    ST_CHECK,
    ST_REREAD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the sample, step the turn interval counter
    logic calc;   // push into the window, form the turn products
    logic turn;   // turn test and blinker update
    logic pop;    // drop the aged entry at the head
    logic emit;   // load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic evict;  // head entry is older than the window
  } dp_status_t;

endpackage

// ----- src/tlc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one sensor sample.
// ----------------------------------------------------------------------------
interface tlc_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        sample_time;
  logic signed [31:0] yaw_angle;
  logic signed [15:0] accel_x;

  modport source (output valid, output sample_time, output yaw_angle, output accel_x,
                  input ready);
  modport sink (input valid, input sample_time, input yaw_angle, input accel_x,
                output ready);
endinterface

// ----- src/tlc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lamp result channel
// Valid/ready channel carrying the brake and blinker decision for one sample.
// ----------------------------------------------------------------------------
interface tlc_out_if;
  logic       valid;
  logic       ready;
  logic       brake_on;
  logic [1:0] blinker_action;

  modport source (output valid, output brake_on, output blinker_action, input ready);
  modport sink (input valid, input brake_on, input blinker_action, output ready);
endinterface

// ----- src/tlc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module tlc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output tlc_pkg::cfg_t                  cfg_o
);
  import tlc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_BLINK_PERIOD:  cfg_d.blink_period  = cfg_wdata_i[23:0];
        REG_TURN_INTERVAL: cfg_d.turn_interval = cfg_wdata_i[7:0];
        REG_TURN_THR:      cfg_d.turn_thr      = cfg_wdata_i[TTHR_W-1:0];
        REG_BRAKE_WINDOW:  cfg_d.brake_window  = cfg_wdata_i[23:0];
        REG_BRAKE_THR:     cfg_d.brake_thr     = cfg_wdata_i[BTHR_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_period  <= RST_BLINK_PERIOD;
      cfg_q.turn_interval <= RST_TURN_INTERVAL;
      cfg_q.turn_thr      <= RST_TURN_THR;
      cfg_q.brake_window  <= RST_BRAKE_WINDOW;
      cfg_q.brake_thr     <= RST_BRAKE_THR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/tlc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light sequencer
// Steps one sample through push, turn test and eviction; owns both handshakes.
// ----------------------------------------------------------------------------
module tlc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tlc_pkg::dp_status_t status_i,
  output tlc_pkg::ctrl_cmd_t  cmd_o
);
  import tlc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_TURN;
      end
      ST_TURN: begin
        cmd_o.turn = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.evict) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_REREAD;
        end else if (!out_valid_q || out_ready_i) begin
          // result slot free (or freeing now)
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_REREAD: begin
        // new head is being read from the window memory
        state_d = ST_CHECK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/tlc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light datapath
// Window memory with running sum, turn rate test, blinker state, result register.
// ----------------------------------------------------------------------------
module tlc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tlc_pkg::cfg_t                      cfg_i,
  input  tlc_pkg::ctrl_cmd_t                 cmd_i,
  output tlc_pkg::dp_status_t                status_o,
  input  logic [tlc_pkg::STAMP_W-1:0]        sample_time_i,
  input  logic signed [tlc_pkg::YAW_W-1:0]   yaw_angle_i,
  input  logic signed [tlc_pkg::ACCEL_W-1:0] accel_x_i,
  output logic                               brake_on_o,
  output logic [1:0]                         blinker_action_o
);
  import tlc_pkg::*;

  // Sample capture
  logic [STAMP_W-1:0]        stamp_q;
  logic signed [YAW_W-1:0]   yaw_q;
  logic signed [ACCEL_W-1:0] accel_q;
  logic                      check_q;
  logic [7:0]                smp_cnt_q, smp_cnt_d;

  // Window memory
  logic [STAMP_W-1:0] time_mem [WIN_DEPTH];
  logic [ACCEL_W-1:0] accel_mem [WIN_DEPTH];
  logic [STAMP_W-1:0] rd_time_q;
  logic [ACCEL_W-1:0] rd_accel_q;
  logic               mem_we;
  logic [WIN_AW-1:0]  wr_addr;

  logic [WIN_AW-1:0]       head_q, head_d, head_inc;
  logic [WIN_CW-1:0]       count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [WIN_CW:0]         slot_sum;
  logic                    full;

  // Turn and blinker
  logic signed [YAW_W-1:0]    prev_yaw_q, prev_yaw_d;
  logic [STAMP_W-1:0]         prev_turn_q, prev_turn_d;
  logic [STAMP_W-1:0]         last_blink_q, last_blink_d;
  logic                       blink_on_q, blink_on_d;
  side_e                      last_side_q, last_side_d;
  logic signed [YAW_W:0]      yaw_diff;
  logic [STAMP_W-1:0]         elapsed;
  logic signed [CHANGE_W-1:0] change_q;
  logic [LIMIT_W-1:0]         limit_q, limit_d;
  logic signed [TCMP_W-1:0]   chg_x, lim_x;
  logic                       go_left, go_right, period_ok, blink_nxt;
  side_e                      side_new;
  act_e                       action_q, action_d;

  // Brake decision and eviction test
  logic [STAMP_W-1:0]       age;
  logic [PROD_W-1:0]        brake_prod;
  logic signed [CMP_W-1:0]  sum_x, lim_brake;
  logic                     brake;
  logic                     brake_q;
  act_e                     act_out_q;

  // ---------------- window bookkeeping ----------------
  assign full     = (count_q == WIN_CW'(WIN_DEPTH));
  assign head_inc = (head_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    slot_sum = (WIN_CW+1)'(head_q) + (WIN_CW+1)'(count_q);
    if (slot_sum >= (WIN_CW+1)'(WIN_DEPTH)) begin
      slot_sum = slot_sum - (WIN_CW+1)'(WIN_DEPTH);
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    sum_d   = sum_q;
    mem_we  = 1'b0;
    wr_addr = slot_sum[WIN_AW-1:0];
    if (cmd_i.calc) begin
      mem_we = 1'b1;
      if (full) begin
        // drop oldest, new entry lands in its slot
        wr_addr = head_q;
        head_d  = head_inc;
        sum_d   = sum_q + SUM_W'(accel_q) - SUM_W'($signed(rd_accel_q));
      end else begin
        count_d = count_q + 1'b1;
        sum_d   = sum_q + SUM_W'(accel_q);
      end
    end else if (cmd_i.pop) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
      sum_d   = sum_q - SUM_W'($signed(rd_accel_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[wr_addr]  <= stamp_q;
      accel_mem[wr_addr] <= accel_q;
    end
    rd_time_q  <= time_mem[head_q];
    rd_accel_q <= accel_mem[head_q];
  end

  assign age            = stamp_q - rd_time_q;
  assign status_o.evict = (count_q != '0) && (age > STAMP_W'(cfg_i.brake_window));

  assign brake_prod = PROD_W'(cfg_i.brake_thr) * PROD_W'(count_q);
  assign sum_x      = CMP_W'(sum_q);
  assign lim_brake  = -$signed(CMP_W'(brake_prod));
  assign brake      = (sum_x <= lim_brake);

  // ---------------- turn test ----------------
  assign smp_cnt_d = (smp_cnt_q >= cfg_i.turn_interval) ? '0 : smp_cnt_q + 1'b1;
  assign yaw_diff  = (YAW_W+1)'(yaw_q) - (YAW_W+1)'(prev_yaw_q);
  assign elapsed   = stamp_q - prev_turn_q;
  assign limit_d   = LIMIT_W'(cfg_i.turn_thr) * LIMIT_W'(elapsed);

  assign chg_x     = TCMP_W'(change_q);
  assign lim_x     = $signed({1'b0, limit_q});
  assign go_left   = (chg_x >= lim_x);
  assign go_right  = (chg_x <= -lim_x);
  assign period_ok = ((stamp_q - last_blink_q) >= STAMP_W'(cfg_i.blink_period));
  assign side_new  = go_left ? SIDE_LEFT : SIDE_RIGHT;
  assign blink_nxt = (side_new != last_side_q) ? 1'b1 : !blink_on_q;

  always_comb begin
    prev_yaw_d   = prev_yaw_q;
    prev_turn_d  = prev_turn_q;
    last_blink_d = last_blink_q;
    blink_on_d   = blink_on_q;
    last_side_d  = last_side_q;
    action_d     = action_q;
    if (cmd_i.turn) begin
      action_d = ACT_NONE;
      if (check_q) begin
        prev_yaw_d  = yaw_q;
        prev_turn_d = stamp_q;
        if (go_left || go_right) begin
          last_side_d = side_new;
          if (period_ok) begin
            last_blink_d = stamp_q;
            blink_on_d   = blink_nxt;
            if (!blink_nxt) begin
              action_d = ACT_BLANK;
            end else if (go_left) begin
              action_d = ACT_LEFT;
            end else begin
              action_d = ACT_RIGHT;
            end
          end
        end else begin
          action_d = ACT_BLANK;
        end
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_cnt_q    <= '0;
      head_q       <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      prev_yaw_q   <= '0;
      prev_turn_q  <= '0;
      last_blink_q <= '0;
      blink_on_q   <= 1'b0;
      last_side_q  <= SIDE_NONE;
    end else begin
      if (cmd_i.load) begin
        smp_cnt_q <= smp_cnt_d;
      end
      head_q       <= head_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
      prev_yaw_q   <= prev_yaw_d;
      prev_turn_q  <= prev_turn_d;
      last_blink_q <= last_blink_d;
      blink_on_q   <= blink_on_d;
      last_side_q  <= last_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stamp_q <= sample_time_i;
      yaw_q   <= yaw_angle_i;
      accel_q <= accel_x_i;
      check_q <= (smp_cnt_q >= cfg_i.turn_interval);
    end
    if (cmd_i.calc) begin
      change_q <= {yaw_diff, 10'b0};
      limit_q  <= limit_d;
    end
    action_q <= action_d;
    if (cmd_i.emit) begin
      brake_q   <= brake;
      act_out_q <= action_q;
    end
  end

  assign brake_on_o       = brake_q;
  assign blinker_action_o = act_out_q;

endmodule

// ----- src/tail_light_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light controller
// Brake lamp from a time-windowed acceleration average, blinker from yaw rate.
// ----------------------------------------------------------------------------
// One result per sample. A sample holds the sequencer through the transfer
// cycle, then push, turn test and check. Its result is loaded in the check
// step, which is reached again through a reread step after each pop of a
// window entry that ages out; the window memory has a single registered read
// port, so each eviction waits for a fresh read of the new head. The result
// sits in an output register, so the next sample is taken while an earlier
// result still waits; a finished sample holds in the check step only if the
// previous result has still not been taken. No clearing pass after reset:
// the window memory is only read at entries the fill count covers.
// ----------------------------------------------------------------------------
//
// Brake: each sample is pushed into a 64-entry FIFO (oldest dropped when full)
// and a running sum of accel_x is kept. Entries older than brake_window_us are
// then popped one by one. The lamp is on when sum <= -brake_threshold * count.
//
// Turn: every (turn_interval+1)th sample compares 1024 * (yaw change since the
// last check) against turn_rate_threshold * (elapsed us). A left or right turn
// toggles the blinker at most once per blink_period_us; a side change restarts
// it lit. No turn blanks the blinker; other samples report "unchanged".
//
// Config writes are taken any cycle but are meant to happen while idle.
// Register indexes: 0 blink_period_us, 1 turn_interval, 2 turn_rate_threshold,
// 3 brake_window_us, 4 brake_threshold; other indexes are dropped.
// ----------------------------------------------------------------------------
module tail_light_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tlc_in_if.sink                         sample_i,
  tlc_out_if.source                      result_o,
  input  logic                           cfg_we_i,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tlc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register file
  tlc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer: owns in ready and result valid
  tlc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Window, turn test, blinker state and result payload
  tlc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_time_i    (sample_i.sample_time),
    .yaw_angle_i      (sample_i.yaw_angle),
    .accel_x_i        (sample_i.accel_x),
    .brake_on_o       (result_o.brake_on),
    .blinker_action_o (result_o.blinker_action)
  );

endmodule

// ----- src/tlc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light controller port checker
// Watches the sample and result channels at the top level ports.
// ----------------------------------------------------------------------------
module tlc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       brake_on_i,
  input logic [1:0] blinker_action_i
);

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(brake_on_i) && $stable(blinker_action_i))
    else $error("result payload changed while stalled");

  // after a transfer the sequencer stays busy through push, turn test and check
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("sample taken while previous one in flight");

  // a new result only comes out of a busy cycle
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a sample in flight");

endmodule

bind tail_light_controller tlc_checker u_tlc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (sample_i.valid),
  .in_ready_i       (sample_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .brake_on_i       (result_o.brake_on),
  .blinker_action_i (result_o.blinker_action)
);

// ----- sim/tlc_lamp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light lamp checker
// Watches the sample, result and register ports, predicts brake and blinker
// decisions from its own copy of the window and turn state, and compares.
// ----------------------------------------------------------------------------
module tlc_lamp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tlc_in_if                              sample_mon,
  tlc_out_if                             result_mon,
  input  logic                           cfg_we_i,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             pending_o,
  output int                             fail_count_o,
  output int                             checked_o,
  output int                             brake_seen_o,
  output int                             lit_seen_o
);
  import tlc_pkg::*;

  typedef struct packed {
    logic brake_on;
    act_e action;
  } lamp_t;

  lamp_t expected_lamps[$];
  cfg_t  regs;

  // Window FIFO shadow
  logic [STAMP_W-1:0]        win_stamp[WIN_DEPTH];
  logic signed [ACCEL_W-1:0] win_accel[WIN_DEPTH];
  int unsigned               win_head;
  int unsigned               win_fill;
  longint                    win_sum;

  // Turn and blinker shadow
  logic [7:0]         skip_count;
  longint             prev_yaw;
  logic [STAMP_W-1:0] prev_turn_stamp;
  logic [STAMP_W-1:0] last_blink_stamp;
  logic               blink_lit;
  side_e              last_side;

  function automatic void drop_oldest();
    win_sum  -= win_accel[win_head];
    win_head  = (win_head + 1) % WIN_DEPTH;
    win_fill--;
  endfunction

  function automatic act_e blink_step(side_e side, logic [STAMP_W-1:0] stamp);
    act_e               act;
    logic [STAMP_W-1:0] since;
    act   = ACT_NONE;
    since = stamp - last_blink_stamp;
    if (since >= STAMP_W'(regs.blink_period)) begin
      last_blink_stamp = stamp;
      blink_lit = (side != last_side) ? 1'b1 : !blink_lit;
      if (!blink_lit) act = ACT_BLANK;
      else act = (side == SIDE_LEFT) ? ACT_LEFT : ACT_RIGHT;
    end
    last_side = side;
    return act;
  endfunction

  function automatic act_e turn_decision(logic [STAMP_W-1:0] stamp,
                                         logic signed [YAW_W-1:0] yaw);
    act_e               act;
    logic [STAMP_W-1:0] elapsed;
    longint             change;
    longint             limit;
    elapsed = stamp - prev_turn_stamp;
    change  = (longint'(yaw) - prev_yaw) * 1024;
    limit   = longint'(regs.turn_thr) * longint'(elapsed);
    if (change >= limit) act = blink_step(SIDE_LEFT, stamp);
    else if (change <= -limit) act = blink_step(SIDE_RIGHT, stamp);
    else act = ACT_BLANK;
    prev_yaw        = yaw;
    prev_turn_stamp = stamp;
    return act;
  endfunction

  function automatic lamp_t predict_lamps(logic [STAMP_W-1:0] stamp,
                                          logic signed [YAW_W-1:0] yaw,
                                          logic signed [ACCEL_W-1:0] accel);
    lamp_t              res;
    int unsigned        slot;
    logic [STAMP_W-1:0] age;
    res.action = ACT_NONE;
    if (skip_count >= regs.turn_interval) begin
      skip_count = '0;
      res.action = turn_decision(stamp, yaw);
    end else begin
      skip_count++;
    end
    // full window: oldest goes before the push
    if (win_fill >= WIN_DEPTH) drop_oldest();
    slot = (win_head + win_fill) % WIN_DEPTH;
    win_stamp[slot] = stamp;
    win_accel[slot] = accel;
    win_fill++;
    win_sum += accel;
    // the new entry has age zero, so this stops before the window empties
    while (win_fill > 0) begin
      age = stamp - win_stamp[win_head];
      if (age <= STAMP_W'(regs.brake_window)) break;
      drop_oldest();
    end
    res.brake_on = (win_sum <= -(longint'(regs.brake_thr) * longint'(win_fill)));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lamp_t want;
    if (!rst_ni) begin
      expected_lamps.delete();
      regs.blink_period  = RST_BLINK_PERIOD;
      regs.turn_interval = RST_TURN_INTERVAL;
      regs.turn_thr      = RST_TURN_THR;
      regs.brake_window  = RST_BRAKE_WINDOW;
      regs.brake_thr     = RST_BRAKE_THR;
      win_head         = 0;
      win_fill         = 0;
      win_sum          = 0;
      skip_count       = '0;
      prev_yaw         = 0;
      prev_turn_stamp  = '0;
      last_blink_stamp = '0;
      blink_lit        = 1'b0;
      last_side        = SIDE_NONE;
      fail_count_o     = 0;
      checked_o        = 0;
      brake_seen_o     = 0;
      lit_seen_o       = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_lamps.size() == 0) begin
          $error("lamp result with no sample pending: brake_on %0b blinker_action %0d",
                 result_mon.brake_on, result_mon.blinker_action);
          fail_count_o++;
        end else begin
          want = expected_lamps.pop_front();
          if (result_mon.brake_on !== want.brake_on) begin
            $error("brake_on mismatch: expected %0b, actual %0b",
                   want.brake_on, result_mon.brake_on);
            fail_count_o++;
          end
          if (result_mon.blinker_action !== want.action) begin
            $error("blinker_action mismatch: expected %0d, actual %0d",
                   want.action, result_mon.blinker_action);
            fail_count_o++;
          end
          checked_o++;
          if (want.brake_on) brake_seen_o++;
          if (want.action inside {ACT_LEFT, ACT_RIGHT}) lit_seen_o++;
        end
      end
      if (sample_mon.valid && sample_mon.ready) begin
        expected_lamps.push_back(predict_lamps(sample_mon.sample_time,
                                               sample_mon.yaw_angle,
                                               sample_mon.accel_x));
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_BLINK_PERIOD:  regs.blink_period  = cfg_wdata_i;
          REG_TURN_INTERVAL: regs.turn_interval = cfg_wdata_i[7:0];
          REG_TURN_THR:      regs.turn_thr      = cfg_wdata_i[TTHR_W-1:0];
          REG_BRAKE_WINDOW:  regs.brake_window  = cfg_wdata_i;
          REG_BRAKE_THR:     regs.brake_thr     = cfg_wdata_i[BTHR_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = expected_lamps.size();
  end

endmodule

// ----- sim/tail_light_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail light controller testbench
// Drives sensor samples and register settings, stalls the result side, and
// lets the lamp checker predict and compare every brake/blinker result.
// ----------------------------------------------------------------------------
module tail_light_controller_tb;
  import tlc_pkg::*;

  localparam int RAND_ITEMS     = 500;
  localparam int NUM_PHASES     = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  // worst case after the last transfer: a full window of evictions, each a pop
  // and a reread step, plus the push, turn test and check steps, with margin
  localparam int DRAIN_CYCLES   = 200;

  // index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  // result-side stall patterns
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PATTERN
  } ready_mode_e;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int pending;
  int fail_count;
  int checked;
  int brake_seen;
  int lit_seen;
  int cycle_count = 0;

  tlc_in_if  sample_if ();
  tlc_out_if result_if ();

  tail_light_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tlc_lamp_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_if),
    .result_mon   (result_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .checked_o    (checked),
    .brake_seen_o (brake_seen),
    .lit_seen_o   (lit_seen)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready follows a pattern that is redrawn after each random run,
  // from always-ready through coin flips to long stalls.
  // --------------------------------------------------------------------------
  ready_mode_e ready_mode = RDY_ALWAYS;
  int          ready_left = 0;

  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(32, 256);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      RDY_ALWAYS:  result_if.ready <= 1'b1;
      RDY_COIN:    result_if.ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:  result_if.ready <= ($urandom_range(0, 7) == 0);
      default:     result_if.ready <= cycle_count[2] ^ cycle_count[4];
    endcase
  end

  // --------------------------------------------------------------------------
  // Sample side state
  // --------------------------------------------------------------------------
  cfg_t                   cur;          // settings now in the block
  logic [STAMP_W-1:0]     now_us;       // running timestamp of the stream
  logic signed [YAW_W-1:0] yaw_now;     // running heading of the stream
  int                     gap_max;      // 0: back-to-back transfers
  int                     burst_left;
  int                     items_sent;
  int                     settings_used;

  // stream shape of the current phase
  int unsigned step_lo;
  int unsigned step_hi;
  int          noise_pct;
  int          accel_spread;
  int          rate_k;               // yaw rate as k/4 of the turn threshold

  // Drop valid for n >= 1 cycles. Never called with zero, so valid is not
  // lowered and raised in the same step.
  task automatic sample_gap(int n);
    sample_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // One transfer on the sample channel; bursts with random gaps between them.
  task automatic push_sample(logic [STAMP_W-1:0] stamp, logic signed [YAW_W-1:0] yaw,
                             logic signed [ACCEL_W-1:0] accel);
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        sample_gap($urandom_range(1, gap_max));
      end
      burst_left--;
    end
    sample_if.valid       <= 1'b1;
    sample_if.sample_time <= stamp;
    sample_if.yaw_angle   <= yaw;
    sample_if.accel_x     <= accel;
    do @(posedge clk_i); while (!sample_if.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every result is back. Each sample makes one
  // result, so the block is idle once nothing is pending.
  task automatic wait_drained();
    sample_gap(1);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  // Registers only change with the block idle.
  task automatic apply_settings(cfg_t s);
    wait_drained();
    write_reg(REG_BLINK_PERIOD, s.blink_period);
    write_reg(REG_TURN_INTERVAL, CFG_DATA_W'(s.turn_interval));
    write_reg(REG_TURN_THR, CFG_DATA_W'(s.turn_thr));
    write_reg(REG_BRAKE_WINDOW, s.brake_window);
    write_reg(REG_BRAKE_THR, CFG_DATA_W'(s.brake_thr));
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk_i);
    cur = s;
    settings_used++;
  endtask

  // Field picker: hits both ends now and then, otherwise a useful range.
  function automatic int unsigned pick_field(int unsigned maxv, int unsigned lo,
                                             int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return maxv;
    return $urandom_range(lo, hi);
  endfunction

  // Mostly a plausible sensor stream (steady steps, yaw rate near the turn
  // threshold, accel near the brake threshold), with some raw noise and
  // occasional time jumps that flush the window.
  task automatic next_sample(output logic [STAMP_W-1:0] stamp,
                             output logic signed [YAW_W-1:0] yaw,
                             output logic signed [ACCEL_W-1:0] accel);
    logic [STAMP_W-1:0] dt;
    longint             dyaw;
    int                 jitter;
    int                 a;
    if ($urandom_range(0, 99) < noise_pct) begin
      now_us  = $urandom;
      yaw_now = $urandom;
      accel   = ACCEL_W'($urandom);
    end else begin
      dt = $urandom_range(step_lo, step_hi);
      if ($urandom_range(0, 39) == 0) dt = $urandom_range(0, 2 * cur.brake_window + 2);
      now_us += dt;
      if ($urandom_range(0, 7) == 0) rate_k = int'($urandom_range(0, 16)) - 8;
      jitter  = int'($urandom_range(0, 4)) - 2;
      dyaw    = (longint'(cur.turn_thr) * longint'(rate_k) * longint'(dt)) / 4096 + jitter;
      yaw_now += YAW_W'(dyaw);
      a = -int'(cur.brake_thr) + int'($urandom_range(0, 400)) - 200
          + int'($urandom_range(0, 2 * accel_spread)) - accel_spread;
      if (a > 32767) a = 32767;
      if (a < -32768) a = -32768;
      accel = ACCEL_W'(a);
    end
    stamp = now_us;
    yaw   = yaw_now;
  endtask

  // Per-phase settings: the first two phases pin every register to its floor
  // and its ceiling, the rest mix extremes with mid values.
  task automatic setup_phase(int phase);
    cfg_t s;
    case (phase)
      0: s = '{blink_period: '0, turn_interval: '0, turn_thr: '0,
               brake_window: '0, brake_thr: '0};
      1: s = '{blink_period: '1, turn_interval: '1, turn_thr: '1,
               brake_window: '1, brake_thr: '1};
      default: begin
        s.blink_period  = 24'(pick_field(24'hFF_FFFF, 0, 20000));
        s.turn_interval = 8'(pick_field(255, 0, 6));
        s.turn_thr      = TTHR_W'(pick_field(16'hFFFF, 1, 2000));
        s.brake_window  = 24'(pick_field(24'hFF_FFFF, 1000, 60000));
        s.brake_thr     = BTHR_W'(pick_field(15'h7FFF, 0, 5000));
      end
    endcase
    apply_settings(s);
    case ($urandom_range(0, 2))
      0: begin step_lo = 0;   step_hi = 50;   end
      1: begin step_lo = 500; step_hi = 5000; end
      default: begin step_lo = 0; step_hi = cur.brake_window / 4 + 1; end
    endcase
    // ceiling phase: small steps so the window fills to its depth
    if (phase == 1) begin step_lo = 0; step_hi = 2000; end
    gap_max      = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    noise_pct    = $urandom_range(3, 15);
    accel_spread = $urandom_range(0, 3000);
    if ($urandom_range(0, 3) == 0) now_us = 32'hFFFF_FFFF - $urandom_range(0, 100000);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [STAMP_W-1:0]      stamp;
    logic signed [YAW_W-1:0] yaw;
    logic signed [ACCEL_W-1:0] accel;
    int                      per_phase;
    int                      pause_at;

    sample_if.valid       = 1'b0;
    sample_if.sample_time = '0;
    sample_if.yaw_angle   = '0;
    sample_if.accel_x     = '0;
    result_if.ready       = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_wdata             = '0;
    now_us                = '0;
    yaw_now               = '0;
    gap_max               = 2;
    burst_left            = 0;
    items_sent            = 0;
    settings_used         = 0;
    rate_k                = 0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Directed part -----------------------------------------------------
    // Every sample is a turn check, no blink hold-off, short brake window.
    apply_settings('{blink_period: 24'd0, turn_interval: 8'd0, turn_thr: 16'd16,
                     brake_window: 24'd3000, brake_thr: 15'd1229});
    push_sample(32'd1000, 32'sh0000_0000, 16'sh0000);  // no turn: blank
    push_sample(32'd2000, 32'sh0010_0000, 16'sh8000);  // left, lit
    push_sample(32'd3000, 32'sh0020_0000, 16'sh8000);  // left again, toggles off
    push_sample(32'd4000, 32'sh0010_0000, 16'sh7FFF);  // new side right, lit
    push_sample(32'd4000, 32'sh0010_0000, 16'shF000);  // no change, no time: left
    push_sample(32'd5000, 32'sh7FFF_FFFF, 16'sh8000);  // yaw ceiling
    push_sample(32'd6000, 32'sh8000_0000, 16'sh8000);  // yaw floor, full swing right
    push_sample(32'd6000, 32'sh8000_0000, 16'sh0000);  // repeated timestamp
    push_sample(32'd20000, 32'sh0000_0000, 16'sh8000); // jump flushes the window
    push_sample(32'hFFFF_FC00, 32'sh0000_0100, 16'sh8000);
    push_sample(32'h0000_0200, 32'sh0000_0200, 16'sh8000); // wrap of the clock
    push_sample(32'hFFFF_FFFF, 32'shFFFF_0000, 16'sh8000); // time runs backward
    // Long blink hold-off: turns report unchanged; every third sample checked.
    apply_settings('{blink_period: 24'hFF_FFFF, turn_interval: 8'd2, turn_thr: 16'd1,
                     brake_window: 24'hFF_FFFF, brake_thr: 15'd0});
    push_sample(32'h0000_1000, 32'sh0100_0000, 16'sh0000);
    push_sample(32'h0000_2000, 32'sh0200_0000, 16'sh0001);
    push_sample(32'h0000_3000, 32'sh0300_0000, 16'shFFFF);
    push_sample(32'h0000_4000, 32'sh0000_0000, 16'sh7FFF);
    push_sample(32'h0000_5000, 32'shF000_0000, 16'sh8000);
    push_sample(32'h0000_6000, 32'sh1000_0000, 16'sh0000);
    push_sample(32'h0000_7000, 32'sh0000_0000, 16'sh0000);
    now_us  = 32'h0000_7000;
    yaw_now = '0;

    // ---- Random part -------------------------------------------------------
    per_phase = RAND_ITEMS / NUM_PHASES;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      setup_phase(phase);
      // some phases also hold the sender mid-way until everything is back
      pause_at = ($urandom_range(0, 1) == 1) ? $urandom_range(1, per_phase - 1) : -1;
      for (int i = 0; i < per_phase; i++) begin
        if (i == pause_at) wait_drained();
        next_sample(stamp, yaw, accel);
        push_sample(stamp, yaw, accel);
      end
    end

    // ---- Wind-down ---------------------------------------------------------
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d samples under %0d register settings in %0d cycles",
             items_sent, settings_used, cycle_count);
    $display("%0d lamp results checked: %0d with brake on, %0d with a lit arrow",
             checked, brake_seen, lit_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
